// File: sv/kwm_pkg.sv
// shared types and codes for the k-way sorted run merge block
// no dependencies
package kwm_pkg;

  localparam int NUM_RUNS_DEFAULT  = 8;
  localparam int RUN_DEPTH_DEFAULT = 256;
  localparam int KEY_BITS_DEFAULT  = 32;

  typedef enum logic [1:0] {
    FUNC_PUSH  = 2'd0,
    FUNC_POP   = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_NOP   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2,
    STATUS_RSVD  = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [2:0]  run_index;
    logic [31:0] sort_key;
    logic [31:0] entity_id;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] out_key;
    logic [31:0] out_entity;
    logic [2:0]  out_run;
  } out_item_t;

  typedef struct packed {
    func_t       op;
    logic        drop;
    logic [2:0]  run_index;
    logic [31:0] sort_key;
    logic [31:0] entity_id;
  } cmd_t;

endpackage

// File: sv/kwm_in_if.sv
// input channel of the merge block
// depends on kwm_pkg
interface kwm_in_if;
  logic             valid;
  logic             ready;
  kwm_pkg::in_item_t item;
  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

// File: sv/kwm_out_if.sv
// result channel of the merge block
// depends on kwm_pkg
interface kwm_out_if;
  logic               valid;
  logic               ready;
  kwm_pkg::out_item_t item;
  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

// File: sv/kwm_ram.sv
// generic single-port ram with registered read
// no dependencies
module kwm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// File: sv/kwm_front.sv
// front end: accepts input transactions, classifies them, two-entry queue
// depends on kwm_pkg, kwm_in_if
module kwm_front #(
  parameter int NUM_RUNS = kwm_pkg::NUM_RUNS_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  kwm_in_if.sink       in_ch,
  output logic         cmd_valid,
  output kwm_pkg::cmd_t cmd,
  input  logic         cmd_ready
);
  import kwm_pkg::*;

  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;
  cmd_t       classified;
  logic       push;
  logic       pop;

  always_comb begin
    classified.op        = func_t'(in_ch.item.func);
    classified.drop      = (int'(in_ch.item.run_index) >= NUM_RUNS);
    classified.run_index = in_ch.item.run_index;
    classified.sort_key  = in_ch.item.sort_key;
    classified.entity_id = in_ch.item.entity_id;
  end

  assign in_ch.ready = (cnt != 2'd2);
  assign cmd_valid   = (cnt != 2'd0);
  assign cmd         = q[rd_ptr];
  assign push        = in_ch.valid && in_ch.ready;
  assign pop         = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= classified;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// File: sv/kwm_back.sv
// back end: run pointers, element store, head scan and result register
// depends on kwm_pkg, kwm_out_if, kwm_ram
module kwm_back #(
  parameter int NUM_RUNS  = kwm_pkg::NUM_RUNS_DEFAULT,
  parameter int RUN_DEPTH = kwm_pkg::RUN_DEPTH_DEFAULT,
  parameter int KEY_BITS  = kwm_pkg::KEY_BITS_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  kwm_pkg::cmd_t cmd,
  output logic          cmd_ready,
  kwm_out_if.source     out_ch
);
  import kwm_pkg::*;

  localparam int RB    = $clog2(NUM_RUNS);
  localparam int IW    = $clog2(NUM_RUNS + 1);
  localparam int PB    = $clog2(RUN_DEPTH);
  localparam int CB    = $clog2(RUN_DEPTH + 1);
  localparam int AB    = $clog2(NUM_RUNS * RUN_DEPTH);
  localparam int WIDTH = KEY_BITS + 32;

  typedef enum logic {IDLE, SCAN} state_t;

  state_t          state;
  logic [PB-1:0]   head [NUM_RUNS];
  logic [PB-1:0]   tail [NUM_RUNS];
  logic [CB-1:0]   count [NUM_RUNS];
  logic [IW-1:0]   iss;
  logic            rd_pend;
  logic            rd_vld;
  logic            found;
  logic [RB-1:0]   best_run;
  logic [KEY_BITS-1:0] best_key;
  logic [31:0]     best_ent;
  logic            out_valid;
  out_item_t       out_item;

  logic            ram_we;
  logic [AB-1:0]   ram_addr;
  logic [WIDTH-1:0] ram_wdata;
  logic [WIDTH-1:0] ram_rdata;
  logic [RB-1:0]   run_sel;
  logic [RB-1:0]   scan_run;
  logic            take;
  logic            run_full;
  logic [KEY_BITS-1:0] rd_key;

  function automatic logic [AB-1:0] slot_addr(logic [RB-1:0] r, logic [PB-1:0] p);
    return AB'(AB'(r) * AB'(RUN_DEPTH) + AB'(p));
  endfunction

  function automatic logic [PB-1:0] next_slot(logic [PB-1:0] p);
    return (p == PB'(RUN_DEPTH - 1)) ? '0 : PB'(p + 1'b1);
  endfunction

  assign cmd_ready = (state == IDLE) && !out_valid;
  assign take      = cmd_valid && cmd_ready;
  assign run_sel   = RB'(cmd.run_index);
  assign scan_run  = iss[RB-1:0];
  assign run_full  = cmd.drop || (count[run_sel] == CB'(RUN_DEPTH));
  assign rd_key    = ram_rdata[WIDTH-1:32];

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = slot_addr(scan_run, head[scan_run]);
    ram_wdata = {KEY_BITS'(cmd.sort_key), cmd.entity_id};
    if (state == IDLE) begin
      ram_addr = slot_addr(run_sel, tail[run_sel]);
      ram_we   = take && (cmd.op == FUNC_PUSH) && !run_full;
    end
  end

  kwm_ram #(.WIDTH(WIDTH), .DEPTH(NUM_RUNS * RUN_DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign out_ch.valid = out_valid;
  assign out_ch.item  = out_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
      iss       <= '0;
      rd_pend   <= 1'b0;
      rd_vld    <= 1'b0;
      found     <= 1'b0;
      for (int i = 0; i < NUM_RUNS; i++) begin
        head[i]  <= '0;
        tail[i]  <= '0;
        count[i] <= '0;
      end
    end else begin
      if (out_valid && out_ch.ready) out_valid <= 1'b0;
      unique case (state)
        IDLE: begin
          if (take) begin
            out_item <= '{status: (cmd.op == FUNC_PUSH && run_full) ? STATUS_FULL : STATUS_OK,
                          out_key: '0, out_entity: '0, out_run: '0};
            unique case (cmd.op)
              FUNC_PUSH: begin
                out_valid <= 1'b1;
                if (!run_full) begin
                  tail[run_sel]  <= next_slot(tail[run_sel]);
                  count[run_sel] <= count[run_sel] + 1'b1;
                end
              end
              FUNC_POP: begin
                state   <= SCAN;
                iss     <= '0;
                rd_pend <= 1'b0;
                found   <= 1'b0;
              end
              FUNC_CLEAR: begin
                out_valid <= 1'b1;
                for (int i = 0; i < NUM_RUNS; i++) begin
                  head[i]  <= '0;
                  tail[i]  <= '0;
                  count[i] <= '0;
                end
              end
              default: out_valid <= 1'b1;
            endcase
          end
        end
        SCAN: begin
          if (iss != IW'(NUM_RUNS)) begin
            rd_pend <= 1'b1;
            rd_vld  <= (count[scan_run] != '0);
            iss     <= iss + 1'b1;
          end else begin
            rd_pend <= 1'b0;
          end
          if (rd_pend && rd_vld && (!found || rd_key < best_key)) begin
            found    <= 1'b1;
            best_run <= RB'(iss - 1'b1);
            best_key <= rd_key;
            best_ent <= ram_rdata[31:0];
          end
          if (iss == IW'(NUM_RUNS) && !rd_pend) begin
            state     <= IDLE;
            out_valid <= 1'b1;
            if (found) begin
              out_item <= '{status: STATUS_OK, out_key: 32'(best_key),
                            out_entity: best_ent, out_run: 3'(best_run)};
              head[best_run]  <= next_slot(head[best_run]);
              count[best_run] <= count[best_run] - 1'b1;
            end else begin
              out_item <= '{status: STATUS_EMPTY, out_key: '0, out_entity: '0, out_run: '0};
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end
endmodule

// File: sv/k_way_sorted_run_merge_top.sv
// top level of the k-way sorted run merge block
// depends on kwm_pkg, kwm_in_if, kwm_out_if, kwm_front, kwm_back
//
//  channel   dir   payload                                     handshake
//  in_ch     in    func, run_index, sort_key, entity_id         valid/ready
//  out_ch    out   status, out_key, out_entity, out_run         valid/ready
//
// push, clear and unused codes: the result is registered when the back end takes the command
// pop: the result waits for the head scan that reads one run per
// cycle through the single store port
// synchronous active-high reset clears pointers and counts; the store is not cleared
// a two-entry queue keeps accepting, until it is full, while a result waits on out_ch
module k_way_sorted_run_merge_top #(
  parameter int NUM_RUNS  = kwm_pkg::NUM_RUNS_DEFAULT,
  parameter int RUN_DEPTH = kwm_pkg::RUN_DEPTH_DEFAULT,
  parameter int KEY_BITS  = kwm_pkg::KEY_BITS_DEFAULT
) (
  input  logic  clk,
  input  logic  rst,
  kwm_in_if.sink    in_ch,
  kwm_out_if.source out_ch
);
  import kwm_pkg::*;

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  kwm_front #(.NUM_RUNS(NUM_RUNS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_ready (cmd_ready)
  );

  kwm_back #(.NUM_RUNS(NUM_RUNS), .RUN_DEPTH(RUN_DEPTH), .KEY_BITS(KEY_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_ready (cmd_ready),
    .out_ch    (out_ch)
  );
endmodule
